>>> rtl/epeo_pkg.sv
`timescale 1ns / 1ps
package epeo_pkg;
  localparam int MaxEdges = 64;
  localparam int Vertices = 7;
  localparam int VW = 3;
  localparam int EW = 7;
  localparam int PairN = Vertices * Vertices;
  localparam int PW = 6;
  localparam int SW = 7;
  localparam int NbW = 4;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdSolve = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_CHECK, ST_FRAME, ST_POPF, ST_POPR, ST_LINK,
    ST_RETIRE, ST_VERIFY, ST_EMIT, ST_FAIL, ST_CLEAR
  } state_e;

  typedef struct packed {
    logic [VW-1:0]  vert;
    logic [NbW-1:0] nb;
    logic [EW-1:0]  edge_no;
    logic           rev;
  } frame_t;

  typedef struct packed {
    logic [EW-1:0] edge_number;
    logic          reversed;
    logic          no_solution;
    logic          last;
  } result_t;
endpackage

>>> rtl/epeo_out_reg.sv
`timescale 1ns / 1ps
module epeo_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  epeo_pkg::result_t  in_res_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output epeo_pkg::result_t  out_res_o
);
  import epeo_pkg::*;
  logic    valid_q;
  result_t res_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

  // holding register for one result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      res_q <= in_res_i;
    end
  end
endmodule

>>> rtl/euler_path_edge_orienter.sv
`timescale 1ns / 1ps
// a load reads the list head, then writes the head and the link; a solve probes
// each neighbor of a frame (forward list, then reverse list) and then retires the frame,
// then each result is read from the path memory and presented, and a clear state ends it.
// one transaction is in flight at a time.
// reset clears control, degrees, visited marks and list heads via valid bits.
module euler_path_edge_orienter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // end_a[2:0], end_b[5:3], zeros
  input  logic       s_axis_tuser,  // cmd
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // edge_number[6:0], reversed[7]
  output logic       m_axis_tuser,  // no_solution
  output logic       m_axis_tlast   // last
);
  import epeo_pkg::*;

  state_e state_q, state_d;

  logic [EW-1:0] edge_total_q;
  logic          ovf_q;
  logic [7:0]    deg_q [Vertices];
  logic [Vertices-1:0] vis_q;
  logic [PairN-1:0] head_vld_q;
  logic [EW-1:0] head_mem [PairN];
  logic [EW-1:0] link_mem [MaxEdges];
  frame_t        stk_mem [MaxEdges+1];
  logic [EW:0]   path_mem [MaxEdges];

  frame_t        top_q;
  logic [SW-1:0] sp_q;
  logic [EW-1:0] cnt_q, emit_q;
  logic [EW-1:0] head_rd_q;
  logic [EW-1:0] link_rd_q;
  logic [EW:0]   path_rd_q;
  logic [5:0]    slot_q;
  logic          rev_q;
  logic          emit_rd_q;

  logic [VW-1:0] a, b;
  logic          acc;
  logic          load_in, load_ok;
  logic [5:0]    slot_in;
  assign a = s_axis_tdata[2:0];
  assign b = s_axis_tdata[5:3];
  assign acc = s_axis_tvalid && s_axis_tready;
  assign load_in = acc && s_axis_tuser == CmdLoad && a < VW'(Vertices) && b < VW'(Vertices);
  assign load_ok = load_in && edge_total_q < EW'(MaxEdges);
  assign slot_in = 6'(a * Vertices + b);

  logic          o_valid, o_ready;
  result_t       o_res, m_res;

  // odd-degree scan and start vertex
  logic [3:0]    odd_cnt;
  logic [VW-1:0] start_v;
  logic          start_odd, start_use;
  always_comb begin
    odd_cnt = '0;
    start_v = '0;
    start_odd = 1'b0;
    start_use = 1'b0;
    for (int i = 0; i < Vertices; i++) begin
      if (deg_q[i] != 8'd0 && !start_odd) begin
        start_v = VW'(i);
        start_use = 1'b1;
      end
      if (deg_q[i][0]) begin
        odd_cnt = odd_cnt + 4'd1;
        start_v = VW'(i);
        start_odd = 1'b1;
      end
    end
  end

  logic unvis;
  always_comb begin
    unvis = 1'b0;
    for (int i = 0; i < Vertices; i++) begin
      if (deg_q[i] != 8'd0 && !vis_q[i]) unvis = 1'b1;
    end
  end

  logic [5:0] slot_f, slot_r;
  assign slot_f = 6'(top_q.vert * Vertices + top_q.nb);
  assign slot_r = 6'(top_q.nb * Vertices + top_q.vert);
  logic [EW-1:0] head_val;
  assign head_val = head_vld_q[slot_q] ? head_rd_q : '0;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc && s_axis_tuser == CmdSolve) state_d = ST_CHECK;
        else if (load_ok) state_d = ST_LOAD;
      end
      ST_LOAD:   state_d = ST_IDLE;
      ST_CHECK: begin
        if (ovf_q || edge_total_q == '0 || odd_cnt > 4'd2 || !start_use) state_d = ST_FAIL;
        else state_d = ST_FRAME;
      end
      ST_FRAME: begin
        if (top_q.nb < NbW'(Vertices)) state_d = ST_POPF;
        else state_d = ST_RETIRE;
      end
      ST_POPF:   state_d = (head_val != '0) ? ST_LINK : ST_POPR;
      ST_POPR:   state_d = (head_val != '0) ? ST_LINK : ST_FRAME;
      ST_LINK:   state_d = ST_FRAME;
      ST_RETIRE: state_d = (sp_q == '0) ? ST_VERIFY : ST_FRAME;
      ST_VERIFY: begin
        if (unvis || cnt_q == '0 || cnt_q != edge_total_q) state_d = ST_FAIL;
        else state_d = ST_EMIT;
      end
      ST_EMIT:   if (o_ready && emit_rd_q && emit_q == '0) state_d = ST_CLEAR;
      ST_FAIL:   if (o_ready) state_d = ST_CLEAR;
      ST_CLEAR:  state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    o_valid = 1'b0;
    o_res = '0;
    unique case (state_q)
      ST_EMIT: begin
        o_valid = emit_rd_q;
        o_res.edge_number = path_rd_q[EW-1:0];
        o_res.reversed = path_rd_q[EW];
        o_res.last = (emit_q == '0);
      end
      ST_FAIL: begin
        o_valid = 1'b1;
        o_res.no_solution = 1'b1;
        o_res.last = 1'b1;
      end
      default: o_valid = 1'b0;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      edge_total_q <= '0;
      ovf_q <= 1'b0;
      vis_q <= '0;
      head_vld_q <= '0;
      sp_q <= '0;
      cnt_q <= '0;
      emit_q <= '0;
      emit_rd_q <= 1'b0;
      for (int i = 0; i < Vertices; i++) deg_q[i] <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (load_in) begin
            if (!load_ok) ovf_q <= 1'b1;
            else begin
              edge_total_q <= edge_total_q + 1'b1;
              // a self loop adds two to its vertex
              for (int i = 0; i < Vertices; i++) begin
                deg_q[i] <= deg_q[i] + {7'd0, a == VW'(i)} + {7'd0, b == VW'(i)};
              end
            end
          end
        end
        ST_LOAD: begin
          head_vld_q[slot_q] <= 1'b1;
        end
        ST_CHECK: begin
          vis_q[start_v] <= 1'b1;
          sp_q <= '0;
          cnt_q <= '0;
        end
        ST_POPF, ST_POPR: begin
          if (head_val != '0 && sp_q < SW'(MaxEdges)) begin
            vis_q[VW'(top_q.nb - 1'b1)] <= 1'b1;
          end
        end
        ST_LINK: begin
          if (sp_q < SW'(MaxEdges)) sp_q <= sp_q + 1'b1;
        end
        ST_RETIRE: begin
          if (top_q.edge_no != '0 && cnt_q < EW'(MaxEdges)) cnt_q <= cnt_q + 1'b1;
          if (sp_q != '0) sp_q <= sp_q - 1'b1;
        end
        ST_VERIFY: begin
          emit_q <= cnt_q - 1'b1;
          emit_rd_q <= 1'b0;
        end
        ST_EMIT: begin
          if (!emit_rd_q) emit_rd_q <= 1'b1;
          else if (o_ready) begin
            emit_rd_q <= 1'b0;
            emit_q <= emit_q - 1'b1;
          end
        end
        ST_CLEAR: begin
          edge_total_q <= '0;
          ovf_q <= 1'b0;
          vis_q <= '0;
          head_vld_q <= '0;
          for (int i = 0; i < Vertices; i++) deg_q[i] <= '0;
        end
        default: ;
      endcase
    end
  end

  // datapath and memories
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (load_ok) begin
          head_rd_q <= head_mem[slot_in];
          slot_q <= slot_in;
        end
      end
      ST_LOAD: begin
        head_mem[slot_q] <= edge_total_q;
        link_mem[PW'(edge_total_q - 1'b1)] <= head_val;
      end
      ST_CHECK: begin
        top_q.vert <= start_v;
        top_q.nb <= '0;
        top_q.edge_no <= '0;
        top_q.rev <= 1'b0;
      end
      ST_FRAME: begin
        if (top_q.nb < NbW'(Vertices)) begin
          head_rd_q <= head_mem[slot_f];
          slot_q <= slot_f;
          top_q.nb <= top_q.nb + 1'b1;
        end
        rev_q <= 1'b0;
      end
      ST_POPF, ST_POPR: begin
        if (head_val != '0) begin
          link_rd_q <= link_mem[6'(head_val - 1'b1)];
        end else if (state_q == ST_POPF) begin
          head_rd_q <= head_mem[6'((top_q.nb - 1'b1) * Vertices + top_q.vert)];
          slot_q <= 6'((top_q.nb - 1'b1) * Vertices + top_q.vert);
          rev_q <= 1'b1;
        end
      end
      ST_LINK: begin
        head_mem[slot_q] <= link_rd_q;
        if (sp_q < SW'(MaxEdges)) begin
          stk_mem[sp_q] <= top_q;
          top_q.vert <= VW'(top_q.nb - 1'b1);
          top_q.nb <= '0;
          top_q.edge_no <= head_val;
          top_q.rev <= rev_q;
        end
      end
      ST_RETIRE: begin
        if (top_q.edge_no != '0 && cnt_q < EW'(MaxEdges)) begin
          path_mem[cnt_q[PW-1:0]] <= {top_q.rev, top_q.edge_no};
        end
        if (sp_q != '0) top_q <= stk_mem[sp_q - 1'b1];
      end
      ST_EMIT: begin
        if (!emit_rd_q) path_rd_q <= path_mem[emit_q[PW-1:0]];
      end
      default: ;
    endcase
  end

  epeo_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (o_valid),
    .in_ready_o (o_ready),
    .in_res_i   (o_res),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_res_o  (m_res)
  );

  assign m_axis_tdata = {m_res.reversed, m_res.edge_number};
  assign m_axis_tuser = m_res.no_solution;
  assign m_axis_tlast = m_res.last;

  // input is taken only while idle
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == ST_IDLE) else $error("ready outside idle");
  // a failure result carries no edge
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == 8'd0))
    else $error("bad failure result");
  // stack never exceeds its depth
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SW'(MaxEdges)) else $error("stack overflow");
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import epeo_pkg::*;

  typedef struct {
    logic [EW-1:0] edge_number;
    logic          reversed;
    logic          no_solution;
    logic          last;
  } path_item_t;

  typedef struct {
    logic          cmd;
    logic [2:0]    a;
    logic [2:0]    b;
    bit            typed;  // expected failure result typed in the table
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tuser = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;

  euler_path_edge_orienter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor copy of the graph
  int unsigned gr_total;
  bit          gr_overflow;
  int unsigned gr_degree[Vertices];
  int unsigned gr_head[PairN];
  int unsigned gr_link[MaxEdges];

  path_item_t  path_q[$];
  int          err_count = 0;
  int          result_count = 0;
  int          solve_count = 0;
  int          success_count = 0;
  bit          quiet_mode = 1'b0;
  bit          watchdog_trip = 1'b0;

  task automatic clear_graph();
    gr_total = 0;
    gr_overflow = 1'b0;
    foreach (gr_degree[i]) gr_degree[i] = 0;
    foreach (gr_head[i]) gr_head[i] = 0;
    foreach (gr_link[i]) gr_link[i] = 0;
  endtask

  function automatic int unsigned take_pair(int unsigned p, int unsigned q);
    int unsigned e;
    e = gr_head[p * Vertices + q];
    if (e != 0) gr_head[p * Vertices + q] = gr_link[(e - 1) % MaxEdges];
    return e;
  endfunction

  task automatic push_fail();
    path_item_t r;
    r.edge_number = '0;
    r.reversed = 1'b0;
    r.no_solution = 1'b1;
    r.last = 1'b1;
    path_q = {path_q, r};
  endtask

  // walk the graph depth first and queue the oriented path
  task automatic predict_path();
    int unsigned odd, top, cnt, p, j, e, rv;
    int          start;
    int unsigned fv[MaxEdges+1];
    int unsigned fnb[MaxEdges+1];
    int unsigned fe[MaxEdges+1];
    int unsigned fr[MaxEdges+1];
    int unsigned pe[MaxEdges];
    int unsigned pr[MaxEdges];
    bit          seen[Vertices];
    path_item_t  r;
    odd = 0; cnt = 0; start = -1;
    foreach (seen[i]) seen[i] = 1'b0;
    if (gr_overflow || gr_total == 0) begin
      push_fail();
      return;
    end
    for (int i = 0; i < Vertices; i++)
      if (gr_degree[i] % 2 == 1) begin
        odd++;
        start = i;
      end
    if (odd > 2) begin
      push_fail();
      return;
    end
    if (start < 0)
      for (int i = 0; i < Vertices; i++) if (gr_degree[i] > 0) start = i;
    fv[0] = unsigned'(start); fnb[0] = 0; fe[0] = 0; fr[0] = 0;
    seen[start] = 1'b1;
    top = 1;
    while (top > 0) begin
      if (fnb[top-1] < Vertices) begin
        p = fv[top-1];
        j = fnb[top-1];
        fnb[top-1]++;
        rv = 0;
        e = take_pair(p, j);
        if (e == 0) begin
          e = take_pair(j, p);
          rv = 1;
        end
        if (e != 0 && top < MaxEdges + 1) begin
          fv[top] = j; fnb[top] = 0; fe[top] = e; fr[top] = rv;
          seen[j] = 1'b1;
          top++;
        end
      end else begin
        if (fe[top-1] != 0 && cnt < MaxEdges) begin
          pe[cnt] = fe[top-1];
          pr[cnt] = fr[top-1];
          cnt++;
        end
        top--;
      end
    end
    for (int i = 0; i < Vertices; i++) if (gr_degree[i] > 0 && !seen[i]) cnt = 0;
    if (cnt == 0 || cnt != gr_total) begin
      push_fail();
      return;
    end
    success_count++;
    for (int i = 0; i < cnt; i++) begin
      r.edge_number = EW'(pe[cnt-1-i]);
      r.reversed = 1'(pr[cnt-1-i]);
      r.no_solution = 1'b0;
      r.last = (i + 1 == cnt);
      path_q = {path_q, r};
    end
  endtask

  task automatic apply_item(logic cmd, logic [2:0] a, logic [2:0] b);
    if (cmd == CmdLoad) begin
      if (a >= Vertices || b >= Vertices) return;
      if (gr_total >= MaxEdges) begin
        gr_overflow = 1'b1;
        return;
      end
      gr_link[gr_total] = gr_head[a * Vertices + b];
      gr_total++;
      gr_head[a * Vertices + b] = gr_total;
      gr_degree[a]++;
      gr_degree[b]++;
    end else begin
      solve_count++;
      predict_path();
      clear_graph();
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // drive one transaction and wait for its acceptance
  task automatic send_item(logic cmd, logic [2:0] a, logic [2:0] b);
    while (!quiet_mode && $urandom_range(99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {2'b00, b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_item(cmd, a, b);
  endtask

  // sink side: random stall and compare
  always @(posedge clk_i) begin
    path_item_t w;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_count++;
        if (path_q.size() == 0) begin
          report_mismatch("result with nothing expected", m_axis_tdata, -1);
        end else begin
          w = path_q.pop_front();
          if (m_axis_tdata[6:0] != w.edge_number)
            report_mismatch("edge_number", m_axis_tdata[6:0], w.edge_number);
          if (m_axis_tdata[7] != w.reversed)
            report_mismatch("reversed", m_axis_tdata[7], w.reversed);
          if (m_axis_tuser != w.no_solution)
            report_mismatch("no_solution", m_axis_tuser, w.no_solution);
          if (m_axis_tlast != w.last)
            report_mismatch("last", m_axis_tlast, w.last);
        end
      end
      m_axis_tready <= quiet_mode || ($urandom_range(99) >= 38);
    end
  end

  // watchdog on cycles without any transaction
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) watchdog_trip <= 1'b1;
  end

  initial begin
    @(posedge watchdog_trip);
    $display("watchdog timeout, %0d results still expected", path_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  stim_row_t rows[$];

  task automatic add_row(logic cmd, logic [2:0] a, logic [2:0] b, bit typed);
    stim_row_t r;
    r.cmd = cmd; r.a = a; r.b = b; r.typed = typed;
    rows = {rows, r};
  endtask

  task automatic load_run(int unsigned n);
    int unsigned v, u, mode;
    mode = $urandom_range(3);
    v = $urandom_range(Vertices - 1);
    for (int i = 0; i < n; i++) begin
      if (mode == 0) begin
        send_item(CmdLoad, 3'($urandom), 3'($urandom));
      end else begin
        // chain walk, mostly well formed
        u = $urandom_range(Vertices - 1);
        if ($urandom_range(1)) send_item(CmdLoad, 3'(v), 3'(u));
        else send_item(CmdLoad, 3'(u), 3'(v));
        v = u;
      end
    end
  endtask

  initial begin
    clear_graph();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: empty solve, loops, extremes, out of range, odd count
    add_row(CmdSolve, 3'd0, 3'd0, 1'b1);
    add_row(CmdLoad, 3'd0, 3'd0, 1'b0);
    add_row(CmdSolve, 3'd0, 3'd0, 1'b0);
    add_row(CmdLoad, 3'd6, 3'd0, 1'b0);
    add_row(CmdLoad, 3'd7, 3'd1, 1'b0);
    add_row(CmdLoad, 3'd1, 3'd7, 1'b0);
    add_row(CmdLoad, 3'd0, 3'd6, 1'b0);
    add_row(CmdLoad, 3'd6, 3'd5, 1'b0);
    add_row(CmdSolve, 3'd7, 3'd7, 1'b0);
    add_row(CmdLoad, 3'd0, 3'd1, 1'b0);
    add_row(CmdLoad, 3'd0, 3'd2, 1'b0);
    add_row(CmdLoad, 3'd0, 3'd3, 1'b0);
    add_row(CmdLoad, 3'd0, 3'd4, 1'b0);
    add_row(CmdSolve, 3'd0, 3'd0, 1'b1);
    add_row(CmdLoad, 3'd1, 3'd2, 1'b0);
    add_row(CmdLoad, 3'd4, 3'd5, 1'b0);
    add_row(CmdSolve, 3'd0, 3'd0, 1'b1);
    add_row(CmdLoad, 3'd3, 3'd3, 1'b0);
    add_row(CmdLoad, 3'd2, 3'd3, 1'b0);
    add_row(CmdLoad, 3'd2, 3'd3, 1'b0);
    add_row(CmdSolve, 3'd5, 3'd2, 1'b0);
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        send_item(rows[i].cmd, rows[i].a, rows[i].b);
        // failure result read off directly: must match the predictor too
        if (path_q.size() == 0 || !path_q[path_q.size()-1].no_solution)
          report_mismatch("table row not a failure", i, 1);
      end else begin
        send_item(rows[i].cmd, rows[i].a, rows[i].b);
      end
    end

    // overflow: 65 loads, then a solve that must fail
    for (int i = 0; i <= MaxEdges; i++)
      send_item(CmdLoad, 3'(i % Vertices), 3'((i + 1) % Vertices));
    send_item(CmdSolve, 3'd0, 3'd0);
    // exactly 64 loads forming a circuit-ish chain, the longest path
    for (int i = 0; i < MaxEdges; i++)
      send_item(CmdLoad, 3'(i % Vertices), 3'((i + 1) % Vertices));
    send_item(CmdSolve, 3'd0, 3'd0);
    s_axis_tvalid <= 1'b0;

    // hold off until every expected result is in
    while (path_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    // random runs, with a stretch of no idling in the middle
    for (int k = 0; k < 12; k++) begin
      quiet_mode = (k >= 4 && k < 8);
      load_run($urandom_range(1, 9));
      send_item(CmdSolve, 3'($urandom), 3'($urandom));
    end
    quiet_mode = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (path_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("covered %0d solves, %0d with a full path, %0d results checked",
             solve_count, success_count, result_count);
    if (err_count == 0 && path_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
